FILE: rtl/core/lpfm_pkg.sv
// shared types and constants of the lru page frame manager
package lpfm_pkg;

   // widest table index and frame number the parameter ranges allow
   localparam int IDX_W   = 12;
   localparam int FRAME_W = 10;
   localparam int STAMP_W = 32;

   localparam int FRAMES_DEFAULT      = 64;
   localparam int TABLE_DEPTH_DEFAULT = 256;
   localparam int MAX_PAGES_DEFAULT   = 16;

   localparam int CSR_DATA_W = 7;
   localparam int CSR_IDX_W  = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAMES_IN_USE     = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_PAGES_PER_PROCESS = 1'b1;

   localparam logic [6:0] FRAMES_IN_USE_RESET     = 7'd64;
   localparam logic [4:0] PAGES_PER_PROCESS_RESET = 5'd4;

   localparam logic CMD_TOUCH    = 1'b0;
   localparam logic CMD_PAGE_OUT = 1'b1;

   localparam logic [1:0] ST_OK           = 2'd0;
   localparam logic [1:0] ST_NO_FRAME     = 2'd1;
   localparam logic [1:0] ST_TABLE_FULL   = 2'd2;
   localparam logic [1:0] ST_NOT_RESIDENT = 2'd3;

   typedef struct packed {
      logic       command;
      logic [7:0] process_id;
      logic [3:0] target_page;
   } req_type;

   typedef struct packed {
      logic [3:0]  page_done;
      logic        hit;
      logic [5:0]  frame;
      logic        evicted;
      logic [7:0]  victim_process;
      logic [3:0]  victim_page;
      logic [1:0]  status;
      logic        process_resident;
      logic [31:0] paged_in_total;
      logic [31:0] paged_out_total;
      logic        last;
   } rsp_type;

   // one buffered result before the residency flag of the whole command is known
   typedef struct packed {
      logic [3:0]  page_done;
      logic        hit;
      logic [5:0]  frame;
      logic        evicted;
      logic [7:0]  victim_process;
      logic [3:0]  victim_page;
      logic [1:0]  status;
      logic [31:0] paged_in_total;
      logic [31:0] paged_out_total;
   } rec_type;

   // lookup token that travels down the cell chain
   typedef struct packed {
      logic               active;
      logic [7:0]         pid;
      logic [3:0]         page;
      logic               page_ok;
      logic               m_found;
      logic [IDX_W-1:0]   m_idx;
      logic               m_res;
      logic [FRAME_W-1:0] m_frame;
      logic               v_found;
      logic [IDX_W-1:0]   v_idx;
      logic [STAMP_W-1:0] v_stamp;
      logic [FRAME_W-1:0] v_frame;
      logic [7:0]         v_process;
      logic [3:0]         v_page;
      logic               any_res;
   } token_type;

   // update broadcast to the cells
   typedef struct packed {
      logic               en;
      logic [IDX_W-1:0]   idx;
      logic               new_entry;
      logic [7:0]         process;
      logic [3:0]         page;
      logic               wr_res;
      logic               res;
      logic               wr_frame;
      logic [FRAME_W-1:0] frame;
      logic               wr_stamp;
      logic [STAMP_W-1:0] stamp;
   } cell_wr_type;

endpackage

FILE: rtl/core/lpfm_cell.sv
// one page table entry with its stage of the lookup chain
module lpfm_cell #(
   parameter int IDX = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  lpfm_pkg::token_type    tok_i,
   input  lpfm_pkg::cell_wr_type  wr_i,
   output lpfm_pkg::token_type    tok_o
);

   localparam logic [lpfm_pkg::IDX_W-1:0] MY_IDX = IDX[lpfm_pkg::IDX_W-1:0];

   logic                           valid_ff;
   logic                           res_ff;
   logic [7:0]                     process_ff;
   logic [3:0]                     page_ff;
   logic [lpfm_pkg::FRAME_W-1:0]   frame_ff;
   logic [lpfm_pkg::STAMP_W-1:0]   stamp_ff;
   lpfm_pkg::token_type            tok_ff;
   lpfm_pkg::token_type            tok_in;
   logic                           sel;
   logic                           match;
   logic                           cand;

   assign sel = wr_i.en && (wr_i.idx == MY_IDX);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         res_ff   <= 1'b0;
      end else if (sel) begin
         if (wr_i.new_entry) begin
            valid_ff <= 1'b1;
         end
         if (wr_i.wr_res) begin
            res_ff <= wr_i.res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (sel) begin
         if (wr_i.new_entry) begin
            process_ff <= wr_i.process;
            page_ff    <= wr_i.page;
         end
         if (wr_i.wr_frame) begin
            frame_ff <= wr_i.frame;
         end
         if (wr_i.wr_stamp) begin
            stamp_ff <= wr_i.stamp;
         end
      end
   end

   always_comb begin
      tok_in = tok_i;
      match  = valid_ff && tok_i.page_ok && (process_ff == tok_i.pid) &&
               (page_ff == tok_i.page);
      cand   = valid_ff && res_ff;
      // first match wins
      if (match && !tok_i.m_found) begin
         tok_in.m_found = 1'b1;
         tok_in.m_idx   = MY_IDX;
         tok_in.m_res   = res_ff;
         tok_in.m_frame = frame_ff;
      end
      // strictly older only, so ties stay with the lower index
      if (cand && (!tok_i.v_found || (stamp_ff < tok_i.v_stamp))) begin
         tok_in.v_found   = 1'b1;
         tok_in.v_idx     = MY_IDX;
         tok_in.v_stamp   = stamp_ff;
         tok_in.v_frame   = frame_ff;
         tok_in.v_process = process_ff;
         tok_in.v_page    = page_ff;
      end
      if (cand && (process_ff == tok_i.pid)) begin
         tok_in.any_res = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in;
      end
   end

   assign tok_o = tok_ff;

endmodule

FILE: rtl/core/lru_page_frame_manager_top.sv
// top level: command sequencer, frame bitmap, result buffer and the entry cell chain
//
// Demand-paging manager with least-recently-used replacement. Each page table entry
// lives in a cell of a chain; a lookup token walks the chain one cell per cycle and
// collects the matching entry, the oldest resident entry and whether the process has
// any resident page. A touch runs one chain pass per page, plus a scan of the frame
// bitmap over the first min(frames_in_use, FRAMES) frames on a miss and an update of
// the entry (eviction and fill); every command ends with one more chain pass for the
// residency flag, after which its results leave one per cycle while rsp_ready is
// high. The block takes a new command only once every result of the previous one
// has been transferred. Configuration is written through csr_wr_en, csr_index and
// csr_wdata.
module lru_page_frame_manager_top #(
   parameter int FRAMES      = lpfm_pkg::FRAMES_DEFAULT,
   parameter int TABLE_DEPTH = lpfm_pkg::TABLE_DEPTH_DEFAULT,
   parameter int MAX_PAGES   = lpfm_pkg::MAX_PAGES_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  lpfm_pkg::req_type                 req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output lpfm_pkg::rsp_type                 rsp_payload,
   input  logic                              csr_wr_en,
   input  logic [lpfm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [lpfm_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int FW  = $clog2(FRAMES);
   localparam int NFW = $clog2(FRAMES + 1);
   localparam int ECW = $clog2(TABLE_DEPTH + 1);
   localparam int PCW = $clog2(MAX_PAGES + 1);
   localparam int BW  = $clog2((MAX_PAGES > 1) ? MAX_PAGES : 2);
   localparam int IW  = lpfm_pkg::IDX_W;
   localparam int XW  = lpfm_pkg::FRAME_W;
   localparam logic [ECW-1:0] DEPTH_FULL = TABLE_DEPTH[ECW-1:0];

   typedef enum logic [9:0] {
      S_IDLE   = 10'b0000000001,
      S_LAUNCH = 10'b0000000010,
      S_WAIT   = 10'b0000000100,
      S_FSCAN  = 10'b0000001000,
      S_EVICT  = 10'b0000010000,
      S_FILL   = 10'b0000100000,
      S_REC    = 10'b0001000000,
      S_FIN    = 10'b0010000000,
      S_FWAIT  = 10'b0100000000,
      S_OUT    = 10'b1000000000
   } state_type;

   state_type              state_ff, state_in;
   logic                   cmd_ff, cmd_in;
   logic [7:0]             pid_ff, pid_in;
   logic [3:0]             pg_ff, pg_in;
   logic [PCW-1:0]         pc_ff, pc_in;
   logic [PCW-1:0]         np_ff, np_in;
   logic [PCW-1:0]         cnt_ff, cnt_in;
   logic [PCW-1:0]         rd_ff, rd_in;
   logic [FW-1:0]          k_ff, k_in;
   logic [FW-1:0]          fsel_ff, fsel_in;
   lpfm_pkg::token_type    tcap_ff, tcap_in;
   lpfm_pkg::rec_type      pend_ff, pend_in;
   logic [FRAMES-1:0]      fused_ff, fused_in;
   logic [31:0]            clk_ff, clk_in;
   logic [ECW-1:0]         ecnt_ff, ecnt_in;
   logic [31:0]            pin_ff, pin_in;
   logic [31:0]            pout_ff, pout_in;
   logic                   anyres_ff, anyres_in;
   lpfm_pkg::cell_wr_type  wr_ff, wr_in;
   logic [6:0]             fcfg_ff;
   logic [4:0]             pcfg_ff;
   lpfm_pkg::rec_type      buf_ff [MAX_PAGES];
   logic                   buf_we;
   lpfm_pkg::rec_type      rec_wr;

   lpfm_pkg::token_type    tok [TABLE_DEPTH+1];
   lpfm_pkg::token_type    tok_launch;
   lpfm_pkg::token_type    tok_end;
   logic [NFW-1:0]         nf;
   logic [31:0]            pc_wide;
   logic [3:0]             cur_pg;
   logic                   cur_pg_ok;
   int                     nf_int;
   int                     np_int;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         fcfg_ff <= lpfm_pkg::FRAMES_IN_USE_RESET;
         pcfg_ff <= lpfm_pkg::PAGES_PER_PROCESS_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            lpfm_pkg::CSR_FRAMES_IN_USE:     fcfg_ff <= csr_wdata[6:0];
            lpfm_pkg::CSR_PAGES_PER_PROCESS: pcfg_ff <= csr_wdata[4:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      nf_int = (32'(fcfg_ff) > FRAMES) ? FRAMES : 32'(fcfg_ff);
      nf     = NFW'(nf_int);
      np_int = (pcfg_ff == 5'd0) ? 1 : ((32'(pcfg_ff) > MAX_PAGES) ? MAX_PAGES : 32'(pcfg_ff));
   end

   assign pc_wide   = 32'(pc_ff);
   assign cur_pg    = (cmd_ff == lpfm_pkg::CMD_PAGE_OUT) ? pg_ff : pc_wide[3:0];
   assign cur_pg_ok = (cmd_ff == lpfm_pkg::CMD_PAGE_OUT) || (pc_wide < 32'd16);

   // launch token for the chain
   always_comb begin
      tok_launch         = '0;
      tok_launch.active  = (state_ff == S_LAUNCH) || (state_ff == S_FIN);
      tok_launch.pid     = pid_ff;
      tok_launch.page    = cur_pg;
      tok_launch.page_ok = cur_pg_ok;
   end

   assign tok[0] = tok_launch;

   for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      lpfm_cell #(
         .IDX(g)
      ) u_cell (
         .clock(clock),
         .reset(reset),
         .tok_i(tok[g]),
         .wr_i (wr_ff),
         .tok_o(tok[g+1])
      );
   end

   assign tok_end = tok[TABLE_DEPTH];

   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      pid_in    = pid_ff;
      pg_in     = pg_ff;
      pc_in     = pc_ff;
      np_in     = np_ff;
      cnt_in    = cnt_ff;
      rd_in     = rd_ff;
      k_in      = k_ff;
      fsel_in   = fsel_ff;
      tcap_in   = tcap_ff;
      pend_in   = pend_ff;
      fused_in  = fused_ff;
      clk_in    = clk_ff;
      ecnt_in   = ecnt_ff;
      pin_in    = pin_ff;
      pout_in   = pout_ff;
      anyres_in = anyres_ff;
      wr_in     = '0;
      buf_we    = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in   = req_payload.command;
               pid_in   = req_payload.process_id;
               pg_in    = req_payload.target_page;
               pc_in    = '0;
               np_in    = PCW'(np_int);
               cnt_in   = '0;
               state_in = S_LAUNCH;
            end
         end
         S_LAUNCH: state_in = S_WAIT;
         S_WAIT: begin
            if (tok_end.active) begin
               tcap_in           = tok_end;
               pend_in           = '0;
               pend_in.page_done = cur_pg;
               state_in          = S_REC;
               if (cmd_ff == lpfm_pkg::CMD_PAGE_OUT) begin
                  if (tok_end.m_found && tok_end.m_res) begin
                     wr_in.en     = 1'b1;
                     wr_in.idx    = tok_end.m_idx;
                     wr_in.wr_res = 1'b1;
                     wr_in.res    = 1'b0;
                     fused_in[tok_end.m_frame[FW-1:0]] = 1'b0;
                     pout_in       = pout_ff + 32'd1;
                     pend_in.frame = tok_end.m_frame[5:0];
                  end else begin
                     pend_in.status = lpfm_pkg::ST_NOT_RESIDENT;
                  end
               end else if (tok_end.m_found && tok_end.m_res) begin
                  wr_in.en       = 1'b1;
                  wr_in.idx      = tok_end.m_idx;
                  wr_in.wr_stamp = 1'b1;
                  wr_in.stamp    = clk_ff;
                  clk_in         = clk_ff + 32'd1;
                  pend_in.hit    = 1'b1;
                  pend_in.frame  = tok_end.m_frame[5:0];
               end else if (!tok_end.m_found && (ecnt_ff == DEPTH_FULL)) begin
                  pend_in.status = lpfm_pkg::ST_TABLE_FULL;
               end else begin
                  k_in     = '0;
                  state_in = S_FSCAN;
               end
            end
         end
         S_FSCAN: begin
            if ((NFW'(k_ff) < nf) && !fused_ff[k_ff]) begin
               fsel_in  = k_ff;
               state_in = S_FILL;
            end else if ((NFW'(k_ff) + NFW'(1)) < nf) begin
               k_in = k_ff + FW'(1);
            end else if (tcap_ff.v_found) begin
               state_in = S_EVICT;
            end else begin
               pend_in.status = lpfm_pkg::ST_NO_FRAME;
               state_in       = S_REC;
            end
         end
         S_EVICT: begin
            wr_in.en               = 1'b1;
            wr_in.idx              = tcap_ff.v_idx;
            wr_in.wr_res           = 1'b1;
            wr_in.res              = 1'b0;
            pout_in                = pout_ff + 32'd1;
            fsel_in                = tcap_ff.v_frame[FW-1:0];
            pend_in.evicted        = 1'b1;
            pend_in.victim_process = tcap_ff.v_process;
            pend_in.victim_page    = tcap_ff.v_page;
            state_in               = S_FILL;
         end
         S_FILL: begin
            fused_in[fsel_ff] = 1'b1;
            wr_in.en          = 1'b1;
            wr_in.new_entry   = !tcap_ff.m_found;
            wr_in.idx         = tcap_ff.m_found ? tcap_ff.m_idx : IW'(ecnt_ff);
            wr_in.process     = pid_ff;
            wr_in.page        = cur_pg;
            wr_in.wr_res      = 1'b1;
            wr_in.res         = 1'b1;
            wr_in.wr_frame    = 1'b1;
            wr_in.frame       = XW'(fsel_ff);
            wr_in.wr_stamp    = 1'b1;
            wr_in.stamp       = clk_ff;
            clk_in            = clk_ff + 32'd1;
            pin_in            = pin_ff + 32'd1;
            if (!tcap_ff.m_found) begin
               ecnt_in = ecnt_ff + ECW'(1);
            end
            pend_in.frame = 6'(fsel_ff);
            state_in      = S_REC;
         end
         S_REC: begin
            buf_we = 1'b1;
            cnt_in = cnt_ff + PCW'(1);
            if ((cmd_ff == lpfm_pkg::CMD_TOUCH) && ((pc_ff + PCW'(1)) < np_ff)) begin
               pc_in    = pc_ff + PCW'(1);
               state_in = S_LAUNCH;
            end else begin
               state_in = S_FIN;
            end
         end
         S_FIN: state_in = S_FWAIT;
         S_FWAIT: begin
            if (tok_end.active) begin
               anyres_in = tok_end.any_res;
               rd_in     = '0;
               state_in  = S_OUT;
            end
         end
         S_OUT: begin
            if (rsp_ready) begin
               rd_in = rd_ff + PCW'(1);
               if ((rd_ff + PCW'(1)) == cnt_ff) begin
                  cnt_in   = '0;
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         cnt_ff    <= '0;
         fused_ff  <= '0;
         clk_ff    <= '0;
         ecnt_ff   <= '0;
         pin_ff    <= '0;
         pout_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         fused_ff  <= fused_in;
         clk_ff    <= clk_in;
         ecnt_ff   <= ecnt_in;
         pin_ff    <= pin_in;
         pout_ff   <= pout_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
      end else begin
         wr_ff <= wr_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff          <= cmd_in;
      pid_ff          <= pid_in;
      pg_ff           <= pg_in;
      pc_ff           <= pc_in;
      np_ff           <= np_in;
      rd_ff           <= rd_in;
      k_ff            <= k_in;
      fsel_ff         <= fsel_in;
      tcap_ff         <= tcap_in;
      pend_ff         <= pend_in;
      anyres_ff       <= anyres_in;
   end

   // counters are already updated when a result is recorded
   always_comb begin
      rec_wr                 = pend_ff;
      rec_wr.paged_in_total  = pin_ff;
      rec_wr.paged_out_total = pout_ff;
   end

   // result buffer
   always_ff @(posedge clock) begin
      if (buf_we) begin
         buf_ff[cnt_ff[BW-1:0]] <= rec_wr;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);

   always_comb begin
      rsp_payload.page_done        = buf_ff[rd_ff[BW-1:0]].page_done;
      rsp_payload.hit              = buf_ff[rd_ff[BW-1:0]].hit;
      rsp_payload.frame            = buf_ff[rd_ff[BW-1:0]].frame;
      rsp_payload.evicted          = buf_ff[rd_ff[BW-1:0]].evicted;
      rsp_payload.victim_process   = buf_ff[rd_ff[BW-1:0]].victim_process;
      rsp_payload.victim_page      = buf_ff[rd_ff[BW-1:0]].victim_page;
      rsp_payload.status           = buf_ff[rd_ff[BW-1:0]].status;
      rsp_payload.process_resident = anyres_ff;
      rsp_payload.paged_in_total   = buf_ff[rd_ff[BW-1:0]].paged_in_total;
      rsp_payload.paged_out_total  = buf_ff[rd_ff[BW-1:0]].paged_out_total;
      rsp_payload.last             = ((rd_ff + PCW'(1)) == cnt_ff);
   end

   a_out_has_results: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (cnt_ff != '0))
      else $error("result transfer with an empty result buffer");

   a_table_bound: assert property (@(posedge clock) disable iff (reset)
      ecnt_ff <= DEPTH_FULL)
      else $error("entry count beyond table depth");

   a_clock_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FILL) |=> (clk_ff == $past(clk_ff) + 32'd1))
      else $error("use clock not advanced on page in");

endmodule

FILE: dv/tb_lru_page_frame_manager_top.sv
// testbench of the lru page frame manager: directed and random commands against a local predictor
`timescale 1ns / 1ps

module tb_lru_page_frame_manager_top;

   localparam int NUM_FRAMES = 64;
   localparam int DEPTH      = 256;
   localparam int PAGES_MAX  = 16;
   localparam longint CYCLE_LIMIT = 20000000;

   logic clock, reset;
   logic req_valid, req_ready;
   lpfm_pkg::req_type req_payload;
   logic rsp_valid, rsp_ready;
   lpfm_pkg::rsp_type rsp_payload;
   logic csr_wr_en;
   logic [lpfm_pkg::CSR_IDX_W-1:0] csr_index;
   logic [lpfm_pkg::CSR_DATA_W-1:0] csr_wdata;

   lru_page_frame_manager_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // local copy of the page table
   bit          pt_valid[DEPTH];
   bit [7:0]    pt_process[DEPTH];
   bit [3:0]    pt_page[DEPTH];
   bit          pt_resident[DEPTH];
   bit [5:0]    pt_frame[DEPTH];
   bit [31:0]   pt_stamp[DEPTH];
   bit          frame_busy[NUM_FRAMES];
   bit [31:0]   use_clock, paged_in_cnt, paged_out_cnt;
   int          entry_cnt;
   bit [6:0]    cfg_frames;
   bit [4:0]    cfg_pages;

   lpfm_pkg::rsp_type pending_rsp[$];
   int          errors;
   bit          quiet;
   int          long_hold_left;
   int          stall_left;
   longint      cycles;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // receiver side: random stalls, plus a long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (long_hold_left > 0) begin
            rsp_ready <= 1'b0;
            long_hold_left--;
         end else if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else if (!quiet && $urandom_range(0, 11) == 0) begin
            rsp_ready <= 1'b0;
            stall_left = $urandom_range(0, 16);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   function automatic void check_field(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
         $display("%0t mismatch %s: expected %0d actual %0d", $time, name, exp_v, act_v);
         errors++;
      end
   endfunction

   // a transfer happens at the next rising edge when both are high at the falling one
   always @(negedge clock) begin
      lpfm_pkg::rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t unexpected result: expected none actual %h", $time, rsp_payload);
            errors++;
         end else begin
            e = pending_rsp.pop_front();
            check_field("page_done", e.page_done, rsp_payload.page_done);
            check_field("hit", e.hit, rsp_payload.hit);
            check_field("frame", e.frame, rsp_payload.frame);
            check_field("evicted", e.evicted, rsp_payload.evicted);
            check_field("victim_process", e.victim_process, rsp_payload.victim_process);
            check_field("victim_page", e.victim_page, rsp_payload.victim_page);
            check_field("status", e.status, rsp_payload.status);
            check_field("process_resident", e.process_resident,
                        rsp_payload.process_resident);
            check_field("paged_in_total", e.paged_in_total, rsp_payload.paged_in_total);
            check_field("paged_out_total", e.paged_out_total, rsp_payload.paged_out_total);
            check_field("last", e.last, rsp_payload.last);
         end
      end
   end

   function automatic lpfm_pkg::rsp_type touch_page(bit [7:0] pid, bit [3:0] pg);
      lpfm_pkg::rsp_type r;
      int idx, fr, victim, nf;
      r = '0;
      idx = -1;
      fr = -1;
      victim = -1;
      nf = (int'(cfg_frames) > NUM_FRAMES) ? NUM_FRAMES : int'(cfg_frames);
      r.page_done = pg;
      for (int i = 0; i < entry_cnt; i++)
         if (pt_valid[i] && pt_process[i] == pid && pt_page[i] == pg) begin
            idx = i;
            break;
         end
      if (idx >= 0 && pt_resident[idx]) begin
         pt_stamp[idx] = use_clock++;
         r.hit = 1'b1;
         r.frame = pt_frame[idx];
      end else if (idx < 0 && entry_cnt >= DEPTH) begin
         r.status = lpfm_pkg::ST_TABLE_FULL;
      end else begin
         for (int i = 0; i < nf; i++)
            if (!frame_busy[i]) begin
               fr = i;
               break;
            end
         if (fr < 0) begin
            for (int i = 0; i < entry_cnt; i++)
               if (pt_valid[i] && pt_resident[i] &&
                   (victim < 0 || pt_stamp[i] < pt_stamp[victim]))
                  victim = i;
            if (victim >= 0) begin
               pt_resident[victim] = 1'b0;
               fr = int'(pt_frame[victim]);
               paged_out_cnt++;
               r.evicted = 1'b1;
               r.victim_process = pt_process[victim];
               r.victim_page = pt_page[victim];
            end
         end
         if (fr < 0) begin
            r.status = lpfm_pkg::ST_NO_FRAME;
         end else begin
            frame_busy[fr] = 1'b1;
            if (idx < 0) begin
               idx = entry_cnt++;
               pt_valid[idx] = 1'b1;
               pt_process[idx] = pid;
               pt_page[idx] = pg;
            end
            pt_resident[idx] = 1'b1;
            pt_frame[idx] = 6'(fr);
            pt_stamp[idx] = use_clock++;
            paged_in_cnt++;
            r.frame = 6'(fr);
         end
      end
      r.paged_in_total = paged_in_cnt;
      r.paged_out_total = paged_out_cnt;
      return r;
   endfunction

   function automatic void predict_command(lpfm_pkg::req_type c);
      lpfm_pkg::rsp_type outs[$];
      lpfm_pkg::rsp_type r;
      int np, idx;
      bit any_res;
      if (c.command == lpfm_pkg::CMD_PAGE_OUT) begin
         idx = -1;
         r = '0;
         r.page_done = c.target_page;
         for (int i = 0; i < entry_cnt; i++)
            if (pt_valid[i] && pt_resident[i] && pt_process[i] == c.process_id &&
                pt_page[i] == c.target_page) begin
               idx = i;
               break;
            end
         if (idx >= 0) begin
            frame_busy[pt_frame[idx]] = 1'b0;
            pt_resident[idx] = 1'b0;
            paged_out_cnt++;
            r.frame = pt_frame[idx];
         end else begin
            r.status = lpfm_pkg::ST_NOT_RESIDENT;
         end
         r.paged_in_total = paged_in_cnt;
         r.paged_out_total = paged_out_cnt;
         outs = {outs, r};
      end else begin
         np = (int'(cfg_pages) < 1) ? 1 :
              (int'(cfg_pages) > PAGES_MAX) ? PAGES_MAX : int'(cfg_pages);
         for (int i = 0; i < np; i++)
            outs = {outs, touch_page(c.process_id, i[3:0])};
      end
      any_res = 1'b0;
      for (int i = 0; i < entry_cnt; i++)
         if (pt_valid[i] && pt_resident[i] && pt_process[i] == c.process_id) begin
            any_res = 1'b1;
            break;
         end
      foreach (outs[i]) begin
         outs[i].process_resident = any_res;
         outs[i].last = (i == outs.size() - 1);
         pending_rsp = {pending_rsp, outs[i]};
      end
   endfunction

   // called just after a rising edge; returns just after the edge that takes the transfer
   task automatic send_command(bit cmd, bit [7:0] pid, bit [3:0] pg);
      lpfm_pkg::req_type c;
      c.command = cmd;
      c.process_id = pid;
      c.target_page = pg;
      req_valid <= 1'b1;
      req_payload <= c;
      @(negedge clock);
      while (!req_ready) @(negedge clock);
      @(posedge clock);
      predict_command(c);
   endtask

   task automatic sender_gap();
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(bit [lpfm_pkg::CSR_IDX_W-1:0] idx,
                            bit [lpfm_pkg::CSR_DATA_W-1:0] val);
      wait_drained();
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == lpfm_pkg::CSR_FRAMES_IN_USE) cfg_frames = val;
      else cfg_pages = val[4:0];
   endtask

   task automatic test_registers_and_extremes();
      write_reg(lpfm_pkg::CSR_FRAMES_IN_USE, 7'd0);
      send_command(lpfm_pkg::CMD_TOUCH, 8'd1, 4'd0);
      send_command(lpfm_pkg::CMD_PAGE_OUT, 8'd1, 4'd0);
      write_reg(lpfm_pkg::CSR_FRAMES_IN_USE, 7'd127);
      write_reg(lpfm_pkg::CSR_PAGES_PER_PROCESS, 7'd0);
      send_command(lpfm_pkg::CMD_TOUCH, 8'd2, 4'd9);
      write_reg(lpfm_pkg::CSR_PAGES_PER_PROCESS, 7'd31);
      send_command(lpfm_pkg::CMD_TOUCH, 8'd255, 4'd0);
      send_command(lpfm_pkg::CMD_PAGE_OUT, 8'd255, 4'd15);
      send_command(lpfm_pkg::CMD_PAGE_OUT, 8'd255, 4'd0);
      send_command(lpfm_pkg::CMD_PAGE_OUT, 8'd255, 4'd0);
      send_command(lpfm_pkg::CMD_TOUCH, 8'd255, 4'd15);
      send_command(lpfm_pkg::CMD_PAGE_OUT, 8'd2, 4'd0);
   endtask

   // small frame counts force evictions, including of pages in frames above the limit
   task automatic test_eviction();
      write_reg(lpfm_pkg::CSR_FRAMES_IN_USE, 7'd2);
      write_reg(lpfm_pkg::CSR_PAGES_PER_PROCESS, 7'd3);
      send_command(lpfm_pkg::CMD_TOUCH, 8'd3, 4'd0);
      send_command(lpfm_pkg::CMD_TOUCH, 8'd4, 4'd0);
      send_command(lpfm_pkg::CMD_TOUCH, 8'd3, 4'd0);
      write_reg(lpfm_pkg::CSR_FRAMES_IN_USE, 7'd1);
      send_command(lpfm_pkg::CMD_TOUCH, 8'd5, 4'd0);
      send_command(lpfm_pkg::CMD_PAGE_OUT, 8'd5, 4'd2);
      send_command(lpfm_pkg::CMD_TOUCH, 8'd4, 4'd0);
      write_reg(lpfm_pkg::CSR_FRAMES_IN_USE, 7'd64);
   endtask

   task automatic test_backpressure();
      write_reg(lpfm_pkg::CSR_PAGES_PER_PROCESS, 7'd2);
      long_hold_left = 800;
      for (int i = 0; i < 6; i++)
         send_command(i[0], 8'($urandom_range(0, 15)), 4'($urandom_range(0, 1)));
      wait_drained();
   endtask

   task automatic test_random();
      bit [6:0] frame_choice[8] = '{7'd1, 7'd2, 7'd3, 7'd5, 7'd8, 7'd16, 7'd64, 7'd100};
      bit [4:0] np;
      bit [7:0] pid;
      bit [3:0] pg;
      bit cmd;
      for (int ph = 0; ph < 7; ph++) begin
         write_reg(lpfm_pkg::CSR_FRAMES_IN_USE, frame_choice[$urandom_range(0, 7)]);
         np = (ph == 3) ? 5'd16 : 5'($urandom_range(1, 4));
         write_reg(lpfm_pkg::CSR_PAGES_PER_PROCESS, 7'(np));
         if (ph == 6) quiet = 1'b1;
         for (int k = 0; k < ((ph == 3) ? 10 : 52); k++) begin
            cmd = ($urandom_range(0, 99) < 35) ? lpfm_pkg::CMD_PAGE_OUT
                                               : lpfm_pkg::CMD_TOUCH;
            pid = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                              : 8'($urandom_range(0, 15));
            pg = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                             : 4'($urandom_range(0, np - 1));
            send_command(cmd, pid, pg);
            // sender pause until everything outstanding has come back
            if (ph == 2 && k == 20) wait_drained();
            sender_gap();
         end
      end
   endtask

   task automatic test_table_full();
      int pid;
      write_reg(lpfm_pkg::CSR_FRAMES_IN_USE, 7'd64);
      write_reg(lpfm_pkg::CSR_PAGES_PER_PROCESS, 7'd16);
      pid = 128;
      while (entry_cnt < DEPTH && pid < 250) begin
         send_command(lpfm_pkg::CMD_TOUCH, 8'(pid), 4'd0);
         pid++;
      end
      send_command(lpfm_pkg::CMD_TOUCH, 8'd251, 4'd0);
      send_command(lpfm_pkg::CMD_TOUCH, 8'd128, 4'd0);
   endtask

   initial begin
      errors = 0;
      quiet = 1'b0;
      long_hold_left = 0;
      stall_left = 0;
      cycles = 0;
      use_clock = 0;
      paged_in_cnt = 0;
      paged_out_cnt = 0;
      entry_cnt = 0;
      cfg_frames = lpfm_pkg::FRAMES_IN_USE_RESET;
      cfg_pages = lpfm_pkg::PAGES_PER_PROCESS_RESET;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_payload <= '0;
      rsp_ready <= 1'b0;
      csr_wr_en <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_registers_and_extremes();
      test_eviction();
      test_backpressure();
      test_random();
      test_table_full();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (600) @(posedge clock);
      if (errors == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
